// File: rtl/sae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types and codes of the sample autocorrelation engine.
// ----------------------------------------------------------------------------
package sae_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SAMPLE_W        = 24;
    localparam int LAG_W           = 10;
    localparam int FUNC_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int S_TDATA_W       = 40;

    // operation codes on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    // result status codes on m_tuser
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LAG   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FEW   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZVAR  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PASS1,
        ST_WAIT1,
        ST_PASS2,
        ST_WAIT2,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                do_clear;
        logic                do_append;
        logic                q_latch;
        logic                acc_clr;
        logic                idx_clr;
        logic                rd_issue;
        logic                pass2;
        logic                mul_start;
        logic                mul_step;
        logic                div_start;
        logic                div_step;
        logic                stat_set;
        logic [STATUS_W-1:0] stat_code;
        logic                res_load;
    } cmd_t;

    typedef struct packed {
        logic few;
        logic lag_ge;
        logic idx_last;
        logic pipe_busy;
        logic v_zero;
        logic mul_last;
        logic div_last;
        logic out_full;
    } sts_t;

endpackage

// File: rtl/sae_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_ctrl
// Sequencer: steps a request through the checks, both passes, scaling,
// division and the result handoff.
// ----------------------------------------------------------------------------
module sae_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sae_pkg::FUNC_W-1:0]  func,
    input  sae_pkg::sts_t               sts,
    output sae_pkg::cmd_t               cmd
);

    sae_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sae_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            sae_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (func)
                        sae_pkg::FUNC_CLEAR:  cmd.do_clear  = 1'b1;
                        sae_pkg::FUNC_APPEND: cmd.do_append = 1'b1;
                        sae_pkg::FUNC_QUERY: begin
                            cmd.q_latch = 1'b1;
                            state_next  = sae_pkg::ST_PRE;
                        end
                        default: ;
                    endcase
                end
            end
            sae_pkg::ST_PRE: begin
                if (sts.few) begin
                    cmd.stat_set  = 1'b1;
                    cmd.stat_code = sae_pkg::STAT_FEW;
                    state_next    = sae_pkg::ST_OUT;
                end else if (sts.lag_ge) begin
                    cmd.stat_set  = 1'b1;
                    cmd.stat_code = sae_pkg::STAT_LAG;
                    state_next    = sae_pkg::ST_OUT;
                end else begin
                    cmd.acc_clr = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = sae_pkg::ST_PASS1;
                end
            end
            sae_pkg::ST_PASS1: begin
                cmd.rd_issue = 1'b1;
                if (sts.idx_last) begin
                    state_next = sae_pkg::ST_WAIT1;
                end
            end
            sae_pkg::ST_WAIT1: begin
                if (!sts.pipe_busy) begin
                    if (sts.v_zero) begin
                        cmd.stat_set  = 1'b1;
                        cmd.stat_code = sae_pkg::STAT_ZVAR;
                        state_next    = sae_pkg::ST_OUT;
                    end else begin
                        cmd.idx_clr = 1'b1;
                        state_next  = sae_pkg::ST_PASS2;
                    end
                end
            end
            sae_pkg::ST_PASS2: begin
                cmd.rd_issue = 1'b1;
                cmd.pass2    = 1'b1;
                if (sts.idx_last) begin
                    state_next = sae_pkg::ST_WAIT2;
                end
            end
            sae_pkg::ST_WAIT2: begin
                cmd.pass2 = 1'b1;
                if (!sts.pipe_busy) begin
                    cmd.mul_start = 1'b1;
                    state_next    = sae_pkg::ST_MUL;
                end
            end
            sae_pkg::ST_MUL: begin
                // all multiplier bits are in once the step count is reached
                if (sts.mul_last) begin
                    cmd.div_start = 1'b1;
                    state_next    = sae_pkg::ST_DIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            sae_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    cmd.stat_set  = 1'b1;
                    cmd.stat_code = sae_pkg::STAT_OK;
                    state_next    = sae_pkg::ST_OUT;
                end
            end
            sae_pkg::ST_OUT: begin
                if (!sts.out_full) begin
                    cmd.res_load = 1'b1;
                    state_next   = sae_pkg::ST_IDLE;
                end
            end
            default: state_next = sae_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/sae_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_datapath
// Sample store, running sum, two-pass product pipeline, shift-add scaling,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module sae_datapath #(
    parameter int MAX_SAMPLES = sae_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = sae_pkg::FRAC_BITS_DEF,
    localparam int CW         = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [sae_pkg::SAMPLE_W-1:0] sample,
    input  logic [sae_pkg::LAG_W-1:0]           lag,
    input  sae_pkg::cmd_t                       cmd,
    output sae_pkg::sts_t                       sts,
    input  logic                                m_tready,
    output logic                                out_valid,
    output logic signed [31:0]                  autocorr,
    output logic [sae_pkg::STATUS_W-1:0]        status,
    output logic [CW-1:0]                       sample_count,
    output logic                                overflowed
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int XW   = sae_pkg::SAMPLE_W;
    localparam int LW   = sae_pkg::LAG_W;
    localparam int SW   = XW + CW;
    localparam int DW   = XW + CW + 1;
    localparam int SPL  = 18;
    localparam int PLW  = DW + SPL + 1;
    localparam int PHW  = 2 * DW - SPL;
    localparam int ACW  = 2 * DW + CW;
    localparam int PRW  = ACW + CW;
    localparam int NUMW = PRW + FRAC_BITS;
    localparam int SCW  = $clog2(NUMW + 1);

    // series state
    logic signed [XW-1:0] mem [MAX_SAMPLES];
    logic [CW-1:0]        count_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 ovf_reg;
    logic [LW-1:0]        lag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.do_clear) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.do_append) begin
            if (32'(count_reg) < MAX_SAMPLES) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SW'(sample);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_latch) begin
            lag_reg <= lag;
        end
    end

    // read side
    logic [AW-1:0]        idx_reg;
    logic [AW:0]          a1_sum;
    logic [AW-1:0]        addr1;
    logic signed [XW-1:0] rd0_reg, rd1_reg;
    logic                 rd_vld_reg;

    assign a1_sum = {1'b0, idx_reg} + (AW + 1)'(lag_reg);
    assign addr1  = cmd.pass2 ? a1_sum[AW-1:0] : idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.do_append && (32'(count_reg) < MAX_SAMPLES)) begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        rd0_reg <= mem[idx_reg];
        rd1_reg <= mem[addr1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.rd_issue) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // deviation, product and accumulate stages
    logic signed [DW-1:0]  n_s, x0_s, x1_s, s_s, d0_next, d1_next;
    logic signed [DW-1:0]  d0_reg, d1_reg;
    logic signed [PLW-1:0] pl_next;
    logic signed [PHW-1:0] ph_next;
    logic signed [PLW-1:0] pl_reg;
    logic signed [PHW-1:0] ph_reg;
    logic signed [ACW-1:0] term;
    logic signed [ACW-1:0] v_reg, a_reg;
    logic                  d_vld_reg, pp_vld_reg;

    assign n_s     = DW'($signed({1'b0, count_reg}));
    assign x0_s    = DW'(rd0_reg);
    assign x1_s    = DW'(rd1_reg);
    assign s_s     = DW'(sum_reg);
    assign d0_next = DW'(n_s * x0_s) - s_s;
    assign d1_next = DW'(n_s * x1_s) - s_s;
    // split the second factor so each partial product keeps its full width
    assign pl_next = d0_reg * $signed({1'b0, d1_reg[SPL-1:0]});
    assign ph_next = d0_reg * $signed(d1_reg[DW-1:SPL]);
    assign term    = ACW'(pl_reg) + (ACW'(ph_reg) <<< SPL);

    always_ff @(posedge aclk) begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
        pl_reg <= pl_next;
        ph_reg <= ph_next;
        if (cmd.acc_clr) begin
            v_reg <= '0;
            a_reg <= '0;
        end else if (pp_vld_reg) begin
            if (cmd.pass2) begin
                a_reg <= a_reg + term;
            end else begin
                v_reg <= v_reg + term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            d_vld_reg  <= 1'b0;
            pp_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_issue;
            d_vld_reg  <= rd_vld_reg;
            pp_vld_reg <= d_vld_reg;
        end
    end

    // shift-add scaling: |A|*(n-1) and V*(n-lag)
    logic [ACW-1:0]  mag_reg, vop_reg;
    logic [CW-1:0]   m1_reg, m2_reg;
    logic [PRW-1:0]  pa_reg, pv_reg;
    logic            neg_reg;
    logic [SCW-1:0]  step_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            neg_reg <= a_reg[ACW-1];
            mag_reg <= a_reg[ACW-1] ? ACW'(-a_reg) : ACW'(a_reg);
            vop_reg <= ACW'(v_reg);
            m1_reg  <= count_reg - 1'b1;
            m2_reg  <= count_reg - CW'(lag_reg);
            pa_reg  <= '0;
            pv_reg  <= '0;
        end else if (cmd.mul_step) begin
            pa_reg <= (pa_reg << 1) + (m1_reg[CW-1] ? PRW'(mag_reg) : '0);
            pv_reg <= (pv_reg << 1) + (m2_reg[CW-1] ? PRW'(vop_reg) : '0);
            m1_reg <= m1_reg << 1;
            m2_reg <= m2_reg << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_start || cmd.div_start) begin
            step_reg <= '0;
        end else if (cmd.mul_step || cmd.div_step) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [NUMW-1:0] num_reg;
    logic [PRW-1:0]  den_reg;
    logic [PRW-1:0]  rem_reg;
    logic [PRW:0]    rem_sh;
    logic            q_bit;
    logic [31:0]     q_reg;
    logic            big_reg;

    assign rem_sh = {rem_reg, num_reg[NUMW-1]};
    assign q_bit  = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg <= NUMW'(pa_reg) << FRAC_BITS;
            den_reg <= pv_reg;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            rem_reg <= q_bit ? PRW'(rem_sh - {1'b0, den_reg}) : PRW'(rem_sh);
            q_reg   <= {q_reg[30:0], q_bit};
            big_reg <= big_reg | q_reg[31];
        end
    end

    // result register
    logic [sae_pkg::STATUS_W-1:0] stat_reg;
    logic signed [31:0]           res_next;
    logic                         big;
    logic                         out_vld_reg;
    logic signed [31:0]           ac_reg;
    logic [sae_pkg::STATUS_W-1:0] st_out_reg;
    logic [CW-1:0]                cnt_out_reg;
    logic                         ovf_out_reg;

    assign big = big_reg | q_reg[31];

    always_comb begin
        if (stat_reg != sae_pkg::STAT_OK) begin
            res_next = '0;
        end else if (neg_reg) begin
            res_next = big ? 32'sh8000_0000 : -$signed(q_reg);
        end else begin
            res_next = big ? 32'sh7FFF_FFFF : $signed(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.stat_set) begin
            stat_reg <= cmd.stat_code;
        end
        if (cmd.res_load) begin
            ac_reg      <= res_next;
            st_out_reg  <= stat_reg;
            cnt_out_reg <= count_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign out_valid    = out_vld_reg;
    assign autocorr     = ac_reg;
    assign status       = st_out_reg;
    assign sample_count = cnt_out_reg;
    assign overflowed   = ovf_out_reg;

    // status back to the sequencer
    always_comb begin
        sts.few       = count_reg < CW'(2);
        sts.lag_ge    = 32'(lag_reg) >= 32'(count_reg);
        sts.idx_last  = (32'(idx_reg) + (cmd.pass2 ? 32'(lag_reg) : 32'd0))
                        == (32'(count_reg) - 32'd1);
        sts.pipe_busy = rd_vld_reg | d_vld_reg | pp_vld_reg;
        sts.v_zero    = v_reg == '0;
        sts.mul_last  = 32'(step_reg) == CW;
        sts.div_last  = 32'(step_reg) == NUMW - 1;
        sts.out_full  = out_vld_reg;
    end

endmodule

// File: rtl/sample_autocorrelation_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_autocorrelation_engine_core
// Normalized sample autocorrelation over a stored series of fixed-point
// samples, answered per lag request.
// ----------------------------------------------------------------------------
// Each request carries an operation on s_tuser. A clear empties the series and
// the sticky overflow flag; an append writes one sample into the store and the
// running sum, or sets the overflow flag when the store is full. Neither returns
// anything. A query returns one result:
// (n-1)*A_j*2^FRAC_BITS / ((n-j)*V), truncated toward zero and saturated to
// 32 bits, with a status on m_tuser. Rejected queries (fewer than two samples,
// lag not below the count) skip both passes and go straight to the result. A
// full query makes two passes through the store, where each pass streams one
// entry a cycle through a four-stage product pipeline on the dual-read store,
// then runs the shift-add scaling over the $clog2(MAX_SAMPLES+1) bits of the
// multiplier and the restoring divider over every numerator bit. One query runs
// at a time; a waiting result sits in the output register while new appends and
// clears are taken.
// ----------------------------------------------------------------------------
module sample_autocorrelation_engine_core #(
    parameter int MAX_SAMPLES = sae_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = sae_pkg::FRAC_BITS_DEF,
    localparam int CW         = $clog2(MAX_SAMPLES + 1),
    localparam int MTW        = ((33 + CW + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sae_pkg::S_TDATA_W-1:0]    s_tdata,  // sample[23:0], lag[33:24]
    input  logic [sae_pkg::FUNC_W-1:0]       s_tuser,  // func[1:0]
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [MTW-1:0]                   m_tdata,  // autocorr, sample_count, overflowed
    output logic [sae_pkg::STATUS_W-1:0]     m_tuser   // status[1:0]
);

    sae_pkg::cmd_t cmd;
    sae_pkg::sts_t sts;

    logic signed [31:0] autocorr;
    logic [CW-1:0]      sample_count;
    logic               overflowed;

    // sequencer: decode the request and walk the query phases
    sae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, arithmetic and the output register
    sae_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample       ($signed(s_tdata[sae_pkg::SAMPLE_W-1:0])),
        .lag          (s_tdata[sae_pkg::SAMPLE_W +: sae_pkg::LAG_W]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .autocorr     (autocorr),
        .status       (m_tuser),
        .sample_count (sample_count),
        .overflowed   (overflowed)
    );

    // pack the result: autocorr lowest, then count, then overflow; zero pad
    assign m_tdata = MTW'({overflowed, sample_count, autocorr});

endmodule

// File: rtl/sae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_checker
// Port-level checks of the autocorrelation engine's result channel.
// ----------------------------------------------------------------------------
module sae_checker #(
    parameter int MAX_SAMPLES = sae_pkg::MAX_SAMPLES_DEF,
    localparam int CW         = $clog2(MAX_SAMPLES + 1),
    localparam int MTW        = ((33 + CW + 7) / 8) * 8
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [MTW-1:0]               m_tdata,
    input logic [sae_pkg::STATUS_W-1:0] m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // drop the value on any failed query
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sae_pkg::STAT_OK |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero autocorr with error status");

    // too-few status only with fewer than two samples
    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == sae_pkg::STAT_FEW |-> m_tdata[32 +: CW] < CW'(2))
        else $error("too-few status with enough samples");

    // other statuses need at least two samples
    a_enough: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sae_pkg::STAT_FEW |-> m_tdata[32 +: CW] >= CW'(2))
        else $error("evaluated query with fewer than two samples");

endmodule

bind sample_autocorrelation_engine_core sae_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_sae_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/sample_autocorrelation_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_autocorrelation_engine_core_tb
// Self-checking bench for the autocorrelation engine. Drives clear, append
// and query requests with random gaps, predicts each query answer with exact
// wide integer arithmetic and compares every result field in order.
// ----------------------------------------------------------------------------
class acorr_scoreboard;
    localparam int DEPTH = 1024;
    localparam int FRAC  = 16;

    logic signed [23:0] series[DEPTH];
    int unsigned        count;
    longint             total;
    bit                 dropped;
    logic [45:0]        answers[$];   // autocorr[31:0], status[33:32], count[44:34], ovf[45]
    int                 errors;

    function void clear_series();
        count   = 0;
        total   = 0;
        dropped = 1'b0;
    endfunction

    // Track one accepted request; queue the answer a query will return.
    function void note_request(logic [1:0] op, logic signed [23:0] smp, logic [9:0] lag);
        logic signed [191:0] var_sum, cov_sum, d0, d1, num, den, quo;
        logic [31:0]         value;
        logic [1:0]          status;
        bit                  neg;
        value  = '0;
        status = sae_pkg::STAT_OK;
        case (op)
            sae_pkg::FUNC_CLEAR: clear_series();
            sae_pkg::FUNC_APPEND: begin
                if (count < DEPTH) begin
                    series[count] = smp;
                    count++;
                    total += smp;
                end else begin
                    dropped = 1'b1;
                end
            end
            sae_pkg::FUNC_QUERY: begin
                if (count < 2) begin
                    status = sae_pkg::STAT_FEW;
                end else if (lag >= count) begin
                    status = sae_pkg::STAT_LAG;
                end else begin
                    var_sum = 0;
                    for (int i = 0; i < count; i++) begin
                        d0 = $signed(count) * series[i] - total;
                        var_sum += d0 * d0;
                    end
                    if (var_sum == 0) begin
                        status = sae_pkg::STAT_ZVAR;
                    end else begin
                        cov_sum = 0;
                        for (int i = 0; i + lag < count; i++) begin
                            d0 = $signed(count) * series[i] - total;
                            d1 = $signed(count) * series[i + lag] - total;
                            cov_sum += d0 * d1;
                        end
                        neg = cov_sum < 0;
                        num = (neg ? -cov_sum : cov_sum) * (count - 1);
                        num = num <<< FRAC;
                        den = var_sum * (count - lag);
                        quo = num / den;
                        if (quo >= 192'sh8000_0000)
                            value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        else
                            value = neg ? -quo[31:0] : quo[31:0];
                    end
                end
                answers.push_back({dropped, count[10:0], status, value});
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [31:0] acorr, logic [1:0] status,
                               logic [10:0] cnt, logic ovf);
        logic [45:0] exp_res;
        if (answers.size() == 0) begin
            $error("unexpected result: autocorr %h status %0d", acorr, status);
            errors++;
            return;
        end
        exp_res = answers.pop_front();
        if (acorr !== exp_res[31:0]) begin
            $error("autocorr: expected %h actual %h", exp_res[31:0], acorr);
            errors++;
        end
        if (status !== exp_res[33:32]) begin
            $error("status: expected %0d actual %0d", exp_res[33:32], status);
            errors++;
        end
        if (cnt !== exp_res[44:34]) begin
            $error("sample_count: expected %0d actual %0d", exp_res[44:34], cnt);
            errors++;
        end
        if (ovf !== exp_res[45]) begin
            $error("overflowed: expected %0d actual %0d", exp_res[45], ovf);
            errors++;
        end
    endfunction
endclass

module sample_autocorrelation_engine_core_tb;

    localparam int  CW        = $clog2(sae_pkg::MAX_SAMPLES_DEF + 1);
    localparam int  MTW       = ((33 + CW + 7) / 8) * 8;
    localparam longint LIMIT  = 2_000_000;

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          s_tvalid = 0;
    logic                          s_tready;
    logic [sae_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [sae_pkg::FUNC_W-1:0]    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 0;
    logic [MTW-1:0]                m_tdata;
    logic [sae_pkg::STATUS_W-1:0]  m_tuser;

    acorr_scoreboard board = new();
    longint cycles = 0;
    bit     feeding = 1;
    int     stall_left = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    sample_autocorrelation_engine_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Offer one request and hold it until taken; idle a random gap first when gaps is set.
    task automatic send(logic [1:0] op, logic [23:0] smp, logic [9:0] lag, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, lag, smp};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, smp, lag);
    endtask

    // Drop the request line and hold off until every answer is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.answers.size() != 0) @(posedge aclk);
    endtask

    // Accept results with a random stall pattern, now and then a long stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata[31:0], m_tuser, m_tdata[32 +: CW], m_tdata[32 + CW]);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left <= $urandom_range(10, 60);
            m_tready   <= 1'b0;
        end else if (feeding && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog on total run time.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int len, mode;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty, single sample, flat series, extremes, lags.
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd0, 0);
        send(sae_pkg::FUNC_APPEND, 24'h7FFFFF, 10'h3FF, 0);
        send(sae_pkg::FUNC_QUERY, 24'hFFFFFF, 10'd0, 0);
        send(sae_pkg::FUNC_APPEND, 24'h7FFFFF, 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd0, 0);      // zero variance
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd2, 0);      // lag not below count
        send(sae_pkg::FUNC_NOP, 24'hABCDEF, 10'h155, 0); // unused code, ignored
        send(sae_pkg::FUNC_APPEND, 24'h800000, 10'd0, 0);
        send(sae_pkg::FUNC_APPEND, 24'h800000, 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd1, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd2, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd3, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'h3FF, 0);
        send(sae_pkg::FUNC_APPEND, 24'h000001, 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd4, 0);
        send(sae_pkg::FUNC_CLEAR, 24'h555555, 10'h2AA, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd0, 0);
        // Alternating series: strongly negative lag-one correlation.
        for (int i = 0; i < 4; i++)
            send(sae_pkg::FUNC_APPEND, (i % 2) ? 24'h800000 : 24'h7FFFFF, 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd1, 0);
        // Sender holds off until every answer is back.
        drain();

        // Longer series of random samples, queried at several lags.
        send(sae_pkg::FUNC_CLEAR, 24'd0, 10'd0, 1);
        for (int i = 0; i < 110; i++)
            send(sae_pkg::FUNC_APPEND, 24'($urandom()), 10'd0, 0);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'd0, 1);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'h3FF, 1);
        send(sae_pkg::FUNC_QUERY, 24'd0, 10'($urandom_range(0, 109)), 1);
        send(sae_pkg::FUNC_CLEAR, 24'd0, 10'd0, 1);

        // Random: short series of random content, queried at random lags.
        for (int k = 0; k < 20; k++) begin
            len  = $urandom_range(0, 9);
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 3) != 0)
                send(sae_pkg::FUNC_CLEAR, 24'($urandom()), 10'($urandom()), 1);
            for (int i = 0; i < len; i++)
                send(sae_pkg::FUNC_APPEND, (mode == 0) ? 24'h001234 :
                     (mode == 1) ? {{12{$urandom_range(0, 1) == 1}}, 12'($urandom())} :
                     24'($urandom()), 10'($urandom()), 1);
            for (int i = 0; i < $urandom_range(1, 3); i++)
                send(sae_pkg::FUNC_QUERY, 24'($urandom()), 10'($urandom_range(0, 11)), 1);
            if ($urandom_range(0, 9) == 0)
                send(sae_pkg::FUNC_NOP, 24'($urandom()), 10'($urandom()), 1);
            if ($urandom_range(0, 9) == 0)
                send(sae_pkg::FUNC_QUERY, 24'($urandom()), 10'($urandom()), 1);
        end

        feeding = 0;
        drain();
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
rtl/sae_pkg.sv
rtl/sae_ctrl.sv
rtl/sae_datapath.sv
rtl/sample_autocorrelation_engine_core.sv
rtl/sae_checker.sv
verif/sample_autocorrelation_engine_core_tb.sv
